// ===== sv/tmq_pkg.sv =====
`timescale 1ns / 1ps

package tmq_pkg;

  // result codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_NO_MSG   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // request kinds carried on tuser
  localparam logic FUNC_SEND = 1'b0;
  localparam logic FUNC_RECV = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND_SCAN,
    S_SEND_PUT,
    S_RECV_SCAN,
    S_RECV_SHIFT,
    S_FINISH
  } state_t;

  // one queued message descriptor
  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] length;
    logic [31:0] mtype;
  } entry_t;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 104;
  localparam int BYTES_W    = 16;
  localparam int OUT_CNT_W  = 5;

  localparam logic [BYTES_W-1:0] LIMIT_RESET = 16'd16384;

endpackage

// ===== sv/tmq_slot_ram.sv =====
`timescale 1ns / 1ps

module tmq_slot_ram #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tmq_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output tmq_pkg::entry_t rd_data_r
);

  tmq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== sv/typed_message_queue.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// in_       in   in_tvalid/tready   tuser: func; tdata: msg_type, msg_len, payload_handle
// out_      out  out_tvalid/tready  tdata: status, out_type, out_size, out_handle,
//                                          queued_count, queued_bytes
// cfg_      in   cfg_wr_en          cfg_wr_data: queue_byte_limit
//
// a rejected request is only accepted and its result registered; a send into a non-empty queue
//   walks down from the tail through every entry at or above its type, then writes itself in;
//   a receive scans from the head to the match, then closes the gap
// the scans are paced by the single read port of the slot memory: one entry per cycle
// reset empties the queue through the count alone, no clearing pass; limit is 16384
// one result register: the next request is taken once the previous result is
//   registered, and a finished request waits while that register is still full

module typed_message_queue #(
  parameter int QUEUE_SLOTS   = 16,
  parameter int MAX_MSG_BYTES = 8192
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] msg_type, [47:32] msg_len, [79:48] payload_handle
  input  logic [tmq_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] func
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] status, [34:3] out_type, [50:35] out_size, [82:51] out_handle,
  // [87:83] queued_count, [103:88] queued_bytes
  output logic [tmq_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [tmq_pkg::BYTES_W-1:0]        cfg_wr_data
);

  localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(QUEUE_SLOTS);
  localparam logic [tmq_pkg::BYTES_W-1:0] MAX_BYTES_C = tmq_pkg::BYTES_W'(MAX_MSG_BYTES);

  // request fields
  logic                  in_func;
  tmq_pkg::entry_t       in_entry;

  assign in_func         = in_tuser[0];
  assign in_entry.mtype  = in_tdata[31:0];
  assign in_entry.length = in_tdata[47:32];
  assign in_entry.handle = in_tdata[79:48];

  // control state
  tmq_pkg::state_t              state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [tmq_pkg::BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [tmq_pkg::BYTES_W-1:0]  limit_r, limit_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // working registers of the request in flight
  tmq_pkg::entry_t              req_r, req_nxt;
  tmq_pkg::entry_t              res_r, res_nxt;
  tmq_pkg::status_t             status_r, status_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [tmq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // slot memory port
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  tmq_pkg::entry_t              ram_wdata;
  logic [IDX_W-1:0]             ram_raddr;
  tmq_pkg::entry_t              ram_rd_data_r;

  tmq_slot_ram #(
    .DEPTH (QUEUE_SLOTS)
  ) u_slot_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_addr   (ram_raddr),
    .rd_data_r (ram_rd_data_r)
  );

  logic [tmq_pkg::BYTES_W:0]    send_sum;
  logic [CNT_W-1:0]             idx_plus1;
  logic [CNT_W-1:0]             idx_plus2;
  logic                         recv_match;
  logic [CNT_W+tmq_pkg::OUT_CNT_W-1:0] count_ext;

  assign send_sum   = {1'b0, bytes_r} + {1'b0, in_entry.length};
  assign idx_plus1  = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_plus2  = CNT_W'(idx_r) + CNT_W'(2);
  // wanted type zero takes the head, anything else an exact match
  assign recv_match = (req_r.mtype == 32'd0) || (ram_rd_data_r.mtype == req_r.mtype);
  assign count_ext  = {{tmq_pkg::OUT_CNT_W{1'b0}}, count_r};

  // no request is taken while reset is held
  assign in_tready  = rst_n && (state_r == tmq_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmq_pkg::S_IDLE;
      count_r     <= '0;
      bytes_r     <= '0;
      limit_r     <= tmq_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    bytes_nxt     = bytes_r;
    limit_nxt     = cfg_wr_en ? cfg_wr_data : limit_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = req_r;
    ram_raddr     = '0;

    case (state_r)
      tmq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          req_nxt    = in_entry;
          res_nxt    = '0;
          status_nxt = tmq_pkg::ST_OK;
          state_nxt  = tmq_pkg::S_FINISH;
          if (in_func == tmq_pkg::FUNC_SEND) begin
            if (in_entry.length == '0 || $signed(in_entry.mtype) <= 32'sd0) begin
              status_nxt = tmq_pkg::ST_INVALID;
            end else if (in_entry.length > MAX_BYTES_C) begin
              status_nxt = tmq_pkg::ST_TOO_BIG;
            end else if (send_sum > {1'b0, limit_r}) begin
              status_nxt = tmq_pkg::ST_NO_SPACE;
            end else if (count_r >= SLOTS_C) begin
              status_nxt = tmq_pkg::ST_FULL;
            end else if (count_r == '0) begin
              // empty queue: new entry goes straight to the head
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_entry;
              count_nxt = count_r + CNT_W'(1);
              bytes_nxt = send_sum[tmq_pkg::BYTES_W-1:0];
            end else begin
              // walk down from the tail, moving larger-or-equal types up
              ram_raddr = IDX_W'(count_r - CNT_W'(1));
              idx_nxt   = IDX_W'(count_r - CNT_W'(1));
              state_nxt = tmq_pkg::S_SEND_SCAN;
            end
          end else begin
            if (in_entry.length == '0) begin
              status_nxt = tmq_pkg::ST_INVALID;
            end else if (count_r == '0) begin
              status_nxt = tmq_pkg::ST_NO_MSG;
            end else begin
              ram_raddr = '0;
              idx_nxt   = '0;
              state_nxt = tmq_pkg::S_RECV_SCAN;
            end
          end
        end
      end

      tmq_pkg::S_SEND_SCAN: begin
        if ($signed(ram_rd_data_r.mtype) >= $signed(req_r.mtype)) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(idx_plus1);
          ram_wdata = ram_rd_data_r;
          if (idx_r == '0) begin
            state_nxt = tmq_pkg::S_SEND_PUT;
          end else begin
            ram_raddr = idx_r - IDX_W'(1);
            idx_nxt   = idx_r - IDX_W'(1);
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(idx_plus1);
          ram_wdata = req_r;
          count_nxt = count_r + CNT_W'(1);
          bytes_nxt = bytes_r + req_r.length;
          state_nxt = tmq_pkg::S_FINISH;
        end
      end

      tmq_pkg::S_SEND_PUT: begin
        // every queued type was at or above the new one
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = req_r;
        count_nxt = count_r + CNT_W'(1);
        bytes_nxt = bytes_r + req_r.length;
        state_nxt = tmq_pkg::S_FINISH;
      end

      tmq_pkg::S_RECV_SCAN: begin
        if (recv_match) begin
          if (req_r.length < ram_rd_data_r.length) begin
            // buffer too small: message stays queued
            status_nxt = tmq_pkg::ST_TOO_BIG;
            state_nxt  = tmq_pkg::S_FINISH;
          end else begin
            res_nxt   = ram_rd_data_r;
            bytes_nxt = bytes_r - ram_rd_data_r.length;
            if (idx_plus1 == count_r) begin
              count_nxt = count_r - CNT_W'(1);
              state_nxt = tmq_pkg::S_FINISH;
            end else begin
              ram_raddr = IDX_W'(idx_plus1);
              state_nxt = tmq_pkg::S_RECV_SHIFT;
            end
          end
        end else if (idx_plus1 == count_r) begin
          status_nxt = tmq_pkg::ST_NO_MSG;
          state_nxt  = tmq_pkg::S_FINISH;
        end else begin
          ram_raddr = IDX_W'(idx_plus1);
          idx_nxt   = IDX_W'(idx_plus1);
        end
      end

      tmq_pkg::S_RECV_SHIFT: begin
        // close the gap: entry idx+1 moves down to idx
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rd_data_r;
        idx_nxt   = IDX_W'(idx_plus1);
        if (idx_plus2 == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = tmq_pkg::S_FINISH;
        end else begin
          ram_raddr = IDX_W'(idx_plus2);
        end
      end

      tmq_pkg::S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {bytes_r, count_ext[tmq_pkg::OUT_CNT_W-1:0],
                           res_r.handle, res_r.length, res_r.mtype, status_r};
          state_nxt     = tmq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tmq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tmq_pkg::*;

  localparam int SLOT_COUNT    = 16;
  localparam int MSG_BYTES_MAX = 8192;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 50;
  localparam int NO_WRITE      = -1;

  // one request as offered on the input channel
  typedef struct {
    logic        func;
    logic [31:0] mtype;
    logic [15:0] size;
    logic [31:0] handle;
  } queue_req_t;

  // one reply as seen on the result channel
  typedef struct {
    status_t     status;
    logic [31:0] mtype;
    logic [15:0] size;
    logic [31:0] handle;
    logic [4:0]  count;
    logic [15:0] bytes;
  } queue_reply_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  logic [0:0]              in_tuser = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_wr_en = 1'b0;
  logic [BYTES_W-1:0]      cfg_wr_data = LIMIT_RESET;

  // requests waiting for the driver, replies waiting for the monitor
  queue_req_t   req_backlog[$];
  queue_reply_t awaited_replies[$];

  // mirror of the message store: sorted descriptors, byte total and limit
  entry_t      mirror_slots[$];
  logic [15:0] mirror_bytes;
  logic [15:0] mirror_limit;

  queue_req_t cur_req;
  int         fail_count = 0;
  int         sender_idle_pct = 0;
  int         rx_stall_pct = 0;
  logic       hold_go = 1'b0;
  logic       out_hold = 1'b0;

  typed_message_queue #(
    .QUEUE_SLOTS   (SLOT_COUNT),
    .MAX_MSG_BYTES (MSG_BYTES_MAX)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // applies one accepted request to the mirror and returns the reply it must give
  function automatic queue_reply_t apply_queue_request(queue_req_t req);
    queue_reply_t rep;
    entry_t       ent;
    int           pos;
    int           found;
    rep = '{status: ST_OK, mtype: '0, size: '0, handle: '0, count: '0, bytes: '0};
    if (req.func == FUNC_SEND) begin
      if (req.size == 0 || $signed(req.mtype) <= 0) begin
        rep.status = ST_INVALID;
      end else if (req.size > MSG_BYTES_MAX) begin
        rep.status = ST_TOO_BIG;
      end else if (32'(mirror_bytes) + 32'(req.size) > 32'(mirror_limit)) begin
        rep.status = ST_NO_SPACE;
      end else if (mirror_slots.size() >= SLOT_COUNT) begin
        rep.status = ST_FULL;
      end else begin
        // in front of the first entry of equal or greater type
        pos = mirror_slots.size();
        for (int i = mirror_slots.size() - 1; i >= 0; i--) begin
          if ($signed(mirror_slots[i].mtype) >= $signed(req.mtype)) pos = i;
        end
        ent.mtype  = req.mtype;
        ent.length = req.size;
        ent.handle = req.handle;
        mirror_slots.insert(pos, ent);
        mirror_bytes = mirror_bytes + req.size;
      end
    end else begin
      if (req.size == 0) begin
        rep.status = ST_INVALID;
      end else begin
        // wanted type zero takes the head, anything else an exact match
        found = -1;
        for (int i = 0; i < mirror_slots.size() && found < 0; i++) begin
          if (req.mtype == 0 || mirror_slots[i].mtype == req.mtype) found = i;
        end
        if (found < 0) begin
          rep.status = ST_NO_MSG;
        end else if (req.size < mirror_slots[found].length) begin
          rep.status = ST_TOO_BIG;
        end else begin
          rep.mtype    = mirror_slots[found].mtype;
          rep.size     = mirror_slots[found].length;
          rep.handle   = mirror_slots[found].handle;
          mirror_bytes = mirror_bytes - mirror_slots[found].length;
          mirror_slots.delete(found);
        end
      end
    end
    rep.count = 5'(mirror_slots.size());
    rep.bytes = mirror_bytes;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // driver: a request is taken at an edge where valid and ready are both high,
  // and it is applied to the mirror right then, so replies line up in order
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      awaited_replies.push_back(apply_queue_request(cur_req));
    end
    if (!in_tvalid || in_tready) begin
      if (rst_n && req_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        cur_req = req_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {cur_req.handle, cur_req.size, cur_req.mtype};
        in_tuser  <= cur_req.func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure: random stalls plus the long hold-off
  always @(posedge clk) begin
    out_tready <= !out_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // long hold-off, counted in its own process; the sender keeps offering meanwhile
  initial begin
    wait (hold_go);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // monitor: every reply is compared field by field with the oldest prediction
  always @(posedge clk) begin
    queue_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        $error("reply with no request outstanding: %h", out_tdata);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status",       32'(want.status), 32'(out_tdata[2:0]));
        check_field("out_type",     want.mtype,       out_tdata[34:3]);
        check_field("out_size",     32'(want.size),   32'(out_tdata[50:35]));
        check_field("out_handle",   want.handle,      out_tdata[82:51]);
        check_field("queued_count", 32'(want.count),  32'(out_tdata[87:83]));
        check_field("queued_bytes", 32'(want.bytes),  32'(out_tdata[103:88]));
      end
    end
  end

  task automatic push_req(logic func, logic [31:0] mtype, logic [15:0] size,
                          logic [31:0] handle);
    queue_req_t req;
    req.func   = func;
    req.mtype  = mtype;
    req.size   = size;
    req.handle = handle;
    req_backlog.push_back(req);
  endtask

  // mostly well-formed traffic over a handful of types so receives find matches,
  // with some raw noise across the full field ranges
  task automatic push_random_req(int send_pct);
    int          pick;
    logic [31:0] mtype;
    logic [15:0] size;
    pick = $urandom_range(99);
    if (pick < 8) begin
      push_req(1'($urandom_range(1)), $urandom, 16'($urandom_range(65535)), $urandom);
    end else if ($urandom_range(99) < send_pct) begin
      mtype = ($urandom_range(4) == 0) ? {1'b0, 31'($urandom)} : $urandom_range(1, 8);
      pick  = $urandom_range(19);
      size  = (pick == 0) ? 16'(MSG_BYTES_MAX) :
              (pick < 3)  ? 16'($urandom_range(1, MSG_BYTES_MAX)) :
                            16'($urandom_range(1, 1500));
      push_req(FUNC_SEND, mtype, size, $urandom);
    end else begin
      pick  = $urandom_range(9);
      mtype = (pick < 4) ? 32'd0 : (pick < 8) ? $urandom_range(1, 8) : $urandom;
      pick  = $urandom_range(9);
      size  = (pick < 7) ? 16'hFFFF :
              (pick < 9) ? 16'($urandom_range(1, 1500)) : 16'($urandom_range(65535));
      push_req(FUNC_RECV, mtype, size, $urandom);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_tvalid || awaited_replies.size() != 0);
  endtask

  initial begin
    // per phase: limit to write (or none), sender idle %, receiver stall %,
    // share of sends, long hold-off
    int   phase_limit[6] = '{65535, NO_WRITE, 1000, 0, 16384, 4096};
    int   phase_idle[6]  = '{0, 76, 0, 23, 23, 0};
    int   phase_stall[6] = '{0, 0, 76, 23, 23, 0};
    int   phase_send[6]  = '{80, 55, 55, 40, 55, 50};
    logic phase_hold[6]  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

    mirror_slots.delete();
    mirror_bytes = '0;
    mirror_limit = LIMIT_RESET;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset limit, no idling
    push_req(FUNC_RECV, 32'd0, 16'd100, 32'h0);                 // empty queue
    push_req(FUNC_RECV, 32'd0, 16'd0, 32'h0);                   // zero buffer
    push_req(FUNC_SEND, 32'd5, 16'd0, 32'h1);                   // zero length
    push_req(FUNC_SEND, 32'd0, 16'd10, 32'h2);                  // type zero
    push_req(FUNC_SEND, 32'h8000_0000, 16'd10, 32'h3);          // most negative type
    push_req(FUNC_SEND, 32'd5, 16'(MSG_BYTES_MAX + 1), 32'h4);  // just over size limit
    push_req(FUNC_SEND, 32'd5, 16'hFFFF, 32'h5);                // largest length
    push_req(FUNC_SEND, 32'h7FFF_FFFF, 16'(MSG_BYTES_MAX), 32'hFFFF_FFFF);
    push_req(FUNC_SEND, 32'd5, 16'd100, 32'hA5A5_0001);
    push_req(FUNC_SEND, 32'd5, 16'd200, 32'h5A5A_0002);         // goes ahead of the equal type
    push_req(FUNC_SEND, 32'd1, 16'd1, 32'h0);                   // new head
    push_req(FUNC_SEND, 32'd3, 16'd10, 32'h3);
    push_req(FUNC_SEND, 32'd2, 16'(MSG_BYTES_MAX), 32'h6);      // over byte budget
    push_req(FUNC_RECV, 32'd5, 16'd99, 32'h0);                  // buffer too small, kept
    push_req(FUNC_RECV, 32'd5, 16'd100, 32'h0);                 // too small for the newer type-5 entry, kept
    push_req(FUNC_RECV, 32'd7, 16'hFFFF, 32'h0);                // no such type
    push_req(FUNC_RECV, 32'hFFFF_FFFB, 16'hFFFF, 32'h0);        // negative wanted type
    push_req(FUNC_RECV, 32'd0, 16'd1, 32'h0);                   // head, any type
    push_req(FUNC_RECV, 32'h7FFF_FFFF, 16'hFFFF, 32'h0);
    push_req(FUNC_RECV, 32'd0, 16'hFFFF, 32'h0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      // limit only changes while nothing is in flight; a lower limit may
      // leave more bytes queued than it allows
      if (phase_limit[p] != NO_WRITE) begin
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 16'(phase_limit[p]);
        mirror_limit = 16'(phase_limit[p]);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
      end
      sender_idle_pct = phase_idle[p];
      rx_stall_pct    = phase_stall[p];
      if (phase_hold[p]) hold_go = 1'b1;
      repeat (75) push_random_req(phase_send[p]);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tmq_pkg.sv
sv/tmq_slot_ram.sv
sv/typed_message_queue.sv
verif/testbench.sv
